[rtl/corridor_steering_with_speed_ramp_macros.svh]
// ----------------------------------------------------------------------------
// Corridor steering assertion macros
// Shared concurrent assertion wrappers for the steering controller. Defining
// ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef CORRIDOR_STEERING_WITH_SPEED_RAMP_MACROS_SVH
`define CORRIDOR_STEERING_WITH_SPEED_RAMP_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define CSTR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSTR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CSTR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSTR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/cstr_pkg.sv]
// ----------------------------------------------------------------------------
// Corridor steering package
// Register indexes, reset values and the structs shared between modules.
// ----------------------------------------------------------------------------
package cstr_pkg;

   localparam int unsigned RegIdxW = 3;

   localparam logic [RegIdxW-1:0] REG_BASE_SPEED     = 3'd0;
   localparam logic [RegIdxW-1:0] REG_TURN_SPEED     = 3'd1;
   localparam logic [RegIdxW-1:0] REG_RAMP_STEP      = 3'd2;
   localparam logic [RegIdxW-1:0] REG_FRONT_LIMIT    = 3'd3;
   localparam logic [RegIdxW-1:0] REG_REAR_LIMIT     = 3'd4;
   localparam logic [RegIdxW-1:0] REG_CENTRE_BAND    = 3'd5;
   localparam logic [RegIdxW-1:0] REG_CROSSING_LIMIT = 3'd6;

   localparam logic [7:0] RST_BASE_SPEED     = 8'd180;
   localparam logic [7:0] RST_TURN_SPEED     = 8'd130;
   localparam logic [7:0] RST_RAMP_STEP      = 8'd6;
   localparam logic [7:0] RST_FRONT_LIMIT    = 8'd20;
   localparam logic [7:0] RST_REAR_LIMIT     = 8'd15;
   localparam logic [7:0] RST_CENTRE_BAND    = 8'd4;
   localparam logic [7:0] RST_CROSSING_LIMIT = 8'd50;

   localparam logic CMD_DECIDE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic [7:0] base_speed;
      logic [7:0] turn_speed;
      logic [7:0] ramp_step;
      logic [7:0] front_limit;
      logic [7:0] rear_limit;
      logic [7:0] centre_band;
      logic [7:0] crossing_limit;
   } cfg_type;

   // Applied and wanted state of one motor.
   typedef struct packed {
      logic [7:0] speed;
      logic [7:0] goal;
      logic       heading;
      logic       wanted;
   } motor_type;

   typedef struct packed {
      logic       halt;
      logic [7:0] goal_a;
      logic [7:0] goal_b;
      logic       fwd_a;
      logic       fwd_b;
   } decision_type;

endpackage

[rtl/cstr_regs.sv]
// ----------------------------------------------------------------------------
// Corridor steering configuration registers
// Seven 8-bit registers written through a plain write port.
// ----------------------------------------------------------------------------
module cstr_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [cstr_pkg::RegIdxW-1:0] csr_index,
   input  logic [7:0]                   csr_data,
   output cstr_pkg::cfg_type            cfg
);
   import cstr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BASE_SPEED:     cfg_in.base_speed     = csr_data;
            REG_TURN_SPEED:     cfg_in.turn_speed     = csr_data;
            REG_RAMP_STEP:      cfg_in.ramp_step      = csr_data;
            REG_FRONT_LIMIT:    cfg_in.front_limit    = csr_data;
            REG_REAR_LIMIT:     cfg_in.rear_limit     = csr_data;
            REG_CENTRE_BAND:    cfg_in.centre_band    = csr_data;
            REG_CROSSING_LIMIT: cfg_in.crossing_limit = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed     <= RST_BASE_SPEED;
         cfg_ff.turn_speed     <= RST_TURN_SPEED;
         cfg_ff.ramp_step      <= RST_RAMP_STEP;
         cfg_ff.front_limit    <= RST_FRONT_LIMIT;
         cfg_ff.rear_limit     <= RST_REAR_LIMIT;
         cfg_ff.centre_band    <= RST_CENTRE_BAND;
         cfg_ff.crossing_limit <= RST_CROSSING_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/cstr_decide.sv]
// ----------------------------------------------------------------------------
// Corridor steering decision logic
// Turns four distances into motor goals and wanted directions.
// ----------------------------------------------------------------------------
module cstr_decide (
   input  cstr_pkg::cfg_type      cfg,
   input  logic [7:0]             left_range,
   input  logic [7:0]             right_range,
   input  logic [7:0]             front_range,
   input  logic [7:0]             rear_range,
   output cstr_pkg::decision_type dec
);
   import cstr_pkg::*;

   logic       left_wider;
   logic [7:0] side_gap;

   assign left_wider = left_range > right_range;
   assign side_gap   = left_wider ? (left_range - right_range)
                                  : (right_range - left_range);

   always_comb begin
      dec.halt   = 1'b0;
      dec.goal_a = cfg.base_speed;
      dec.goal_b = cfg.base_speed;
      dec.fwd_a  = 1'b1;
      dec.fwd_b  = 1'b1;
      if (front_range < cfg.front_limit) begin
         // Pivot toward the wider side: the motor on that side backs up.
         dec.halt  = 1'b1;
         dec.fwd_a = !left_wider;
         dec.fwd_b = left_wider;
      end else if (rear_range < cfg.rear_limit) begin
         dec.halt = 1'b1;
      end else if (side_gap > cfg.crossing_limit) begin
         dec.halt = 1'b0;
      end else if (side_gap < cfg.centre_band) begin
         dec.halt = 1'b0;
      end else if (left_wider) begin
         dec.goal_b = cfg.turn_speed;
      end else begin
         dec.goal_a = cfg.turn_speed;
      end
   end

endmodule

[rtl/cstr_ramp.sv]
// ----------------------------------------------------------------------------
// Corridor steering speed ramp
// One tick of one motor: slow to zero before a reversal, else step toward
// the goal without overshoot.
// ----------------------------------------------------------------------------
module cstr_ramp (
   input  cstr_pkg::motor_type cur,
   input  logic [7:0]          ramp_step,
   output cstr_pkg::motor_type nxt
);
   import cstr_pkg::*;

   logic       reversing;
   logic [7:0] up_gap;
   logic [7:0] down_gap;

   assign reversing = (cur.speed != 8'd0) && (cur.heading != cur.wanted);
   assign up_gap    = cur.goal - cur.speed;
   assign down_gap  = cur.speed - cur.goal;

   always_comb begin
      nxt = cur;
      if (reversing) begin
         nxt.speed = (cur.speed > ramp_step) ? (cur.speed - ramp_step) : 8'd0;
      end else begin
         nxt.heading = cur.wanted;
         if (cur.speed < cur.goal) begin
            nxt.speed = (up_gap > ramp_step) ? (cur.speed + ramp_step) : cur.goal;
         end else if (cur.speed > cur.goal) begin
            nxt.speed = (down_gap > ramp_step) ? (cur.speed - ramp_step) : cur.goal;
         end
      end
   end

endmodule

[rtl/corridor_steering_with_speed_ramp.sv]
// ----------------------------------------------------------------------------
// Corridor steering with speed ramp
// A request is taken into the input stage, then moves into the result
// register when that is free. Throughput: one request per cycle while
// rsp_stall does not hold a full result register; the motor state update
// of each request is a single pass of compares and adds between two register
// stages. Reset: synchronous; registers return to their defaults, speeds and
// goals to zero, all headings to forward, and both pipeline stages empty.
//
// A decide request (cmd = 0) picks new goals and wanted directions from the
// four distances; an obstacle also clears the applied speeds at once. A tick
// request (cmd = 1) ramps each motor toward its goal by ramp_step. Every
// request returns one response with both motors' applied direction and PWM.
// ----------------------------------------------------------------------------
`include "corridor_steering_with_speed_ramp_macros.svh"

module corridor_steering_with_speed_ramp (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [7:0]                   req_left_range,
   input  logic [7:0]                   req_right_range,
   input  logic [7:0]                   req_front_range,
   input  logic [7:0]                   req_rear_range,
   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_left_motor_fwd,
   output logic [7:0]                   rsp_left_motor_pwm,
   output logic                         rsp_right_motor_fwd,
   output logic [7:0]                   rsp_right_motor_pwm,
   // Configuration write port.
   input  logic                         csr_write,
   input  logic [cstr_pkg::RegIdxW-1:0] csr_index,
   input  logic [7:0]                   csr_data
);
   import cstr_pkg::*;

   cfg_type      cfg;
   decision_type dec;

   // Input register stage.
   logic       stage_valid_ff;
   logic       stage_cmd_ff;
   logic [7:0] stage_left_ff;
   logic [7:0] stage_right_ff;
   logic [7:0] stage_front_ff;
   logic [7:0] stage_rear_ff;

   // Motor state, updated when a request leaves the input stage.
   motor_type motor_a_ff;
   motor_type motor_b_ff;
   motor_type motor_a_in;
   motor_type motor_b_in;
   motor_type ramp_a;
   motor_type ramp_b;

   // Result register stage.
   logic       rsp_valid_ff;
   logic       rsp_left_fwd_ff;
   logic [7:0] rsp_left_pwm_ff;
   logic       rsp_right_fwd_ff;
   logic [7:0] rsp_right_pwm_ff;

   logic out_free;
   logic advance;
   logic req_take;

   // The result register can be loaded when it is empty or being drained.
   // The input stage drains into it whenever it can, so a new request is
   // taken while an older response still waits for its consumer.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   cstr_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cstr_decide u_decide (
      .cfg         (cfg),
      .left_range  (stage_left_ff),
      .right_range (stage_right_ff),
      .front_range (stage_front_ff),
      .rear_range  (stage_rear_ff),
      .dec         (dec)
   );

   cstr_ramp u_ramp_a (
      .cur       (motor_a_ff),
      .ramp_step (cfg.ramp_step),
      .nxt       (ramp_a)
   );

   cstr_ramp u_ramp_b (
      .cur       (motor_b_ff),
      .ramp_step (cfg.ramp_step),
      .nxt       (ramp_b)
   );

   // Next motor state for the request in the input stage. A decide keeps the
   // applied headings and only clears the applied speeds on an obstacle.
   always_comb begin
      motor_a_in = motor_a_ff;
      motor_b_in = motor_b_ff;
      if (stage_cmd_ff == CMD_TICK) begin
         motor_a_in = ramp_a;
         motor_b_in = ramp_b;
      end else begin
         motor_a_in.goal   = dec.goal_a;
         motor_a_in.wanted = dec.fwd_a;
         motor_b_in.goal   = dec.goal_b;
         motor_b_in.wanted = dec.fwd_b;
         if (dec.halt) begin
            motor_a_in.speed = 8'd0;
            motor_b_in.speed = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         motor_a_ff     <= '{speed: 8'd0, goal: 8'd0, heading: 1'b1, wanted: 1'b1};
         motor_b_ff     <= '{speed: 8'd0, goal: 8'd0, heading: 1'b1, wanted: 1'b1};
      end else begin
         if (req_take) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            motor_a_ff   <= motor_a_in;
            motor_b_ff   <= motor_b_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_cmd_ff   <= req_cmd;
         stage_left_ff  <= req_left_range;
         stage_right_ff <= req_right_range;
         stage_front_ff <= req_front_range;
         stage_rear_ff  <= req_rear_range;
      end
      if (advance) begin
         rsp_left_fwd_ff  <= motor_a_in.heading;
         rsp_left_pwm_ff  <= motor_a_in.speed;
         rsp_right_fwd_ff <= motor_b_in.heading;
         rsp_right_pwm_ff <= motor_b_in.speed;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_motor_fwd  = rsp_left_fwd_ff;
   assign rsp_left_motor_pwm  = rsp_left_pwm_ff;
   assign rsp_right_motor_fwd = rsp_right_fwd_ff;
   assign rsp_right_motor_pwm = rsp_right_pwm_ff;

   // A motor changes its applied direction only while standing still.
   `CSTR_ASSERT_IMP(a_reverse_from_rest, clock, reset,
      !$past(reset) && (motor_a_ff.heading != $past(motor_a_ff.heading)),
      $past(motor_a_ff.speed) == 8'd0)

   // A front obstacle stops both motors in the same update.
   `CSTR_ASSERT_NEXT(a_front_halt, clock, reset,
      advance && (stage_cmd_ff == CMD_DECIDE) && (stage_front_ff < cfg.front_limit),
      (motor_a_ff.speed == 8'd0) && (motor_b_ff.speed == 8'd0))

   // A pending response always mirrors the current motor state.
   `CSTR_ASSERT_IMP(a_rsp_matches_state, clock, reset,
      rsp_valid_ff,
      (rsp_left_pwm_ff == motor_a_ff.speed) && (rsp_right_pwm_ff == motor_b_ff.speed)
      && (rsp_left_fwd_ff == motor_a_ff.heading) && (rsp_right_fwd_ff == motor_b_ff.heading))

endmodule
